@@ rtl/pctc_pkg.sv @@
`timescale 1ns / 1ps
// pctc_pkg: shared types and constants for the point cloud transform/crop block.
// No dependencies; imported by point_cloud_transform_crop and tb.
package pctc_pkg;

   // Coordinate width (16..32); every datapath width below follows from it.
   localparam int COORD_BITS = 24;

   // Rotation entries are signed Q1.14, translation entries signed 21-bit.
   localparam int ROT_W     = 16;
   localparam int TRANS_W   = 21;
   localparam int FRAC_BITS = 14;
   localparam int ROW_W     = 3 * ROT_W;
   localparam int TRANS_REG_W = 3 * TRANS_W;
   localparam int CROP_W    = 24;
   localparam int INTEN_W   = 16;
   localparam int COLOR_W   = 8;

   localparam int PROD_W = ROT_W + COORD_BITS;
   // Three products plus the shifted translation and rounding bias.
   localparam int ACC_W  = (PROD_W + 3 > TRANS_W + FRAC_BITS + 2) ?
                           PROD_W + 3 : TRANS_W + FRAC_BITS + 2;
   localparam int QUOT_W = ACC_W - FRAC_BITS;
   localparam int CMP_W  = (COORD_BITS > CROP_W) ? COORD_BITS : CROP_W;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = TRANS_REG_W;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROT_ROW0     = 3'd0,
      CSR_ROT_ROW1     = 3'd1,
      CSR_ROT_ROW2     = 3'd2,
      CSR_TRANSLATION  = 3'd3,
      CSR_CROP_HEIGHT  = 3'd4,
      CSR_CROP_ENABLE  = 3'd5,
      CSR_MERGE_ENABLE = 3'd6
   } csr_index_type;

   // Reset values: identity rotation, zero offset, crop on at 1403/1024 m.
   localparam logic [ROW_W-1:0] ROT_ROW0_RESET = ROW_W'(48'h0000_0000_4000);
   localparam logic [ROW_W-1:0] ROT_ROW1_RESET = ROW_W'(48'h0000_4000_0000);
   localparam logic [ROW_W-1:0] ROT_ROW2_RESET = ROW_W'(48'h4000_0000_0000);
   localparam logic signed [CROP_W-1:0] CROP_HEIGHT_RESET = CROP_W'(1403);

   // Luminance weights, sum of weights is 256.
   localparam logic [INTEN_W-1:0] LUMA_R = INTEN_W'(77);
   localparam logic [INTEN_W-1:0] LUMA_G = INTEN_W'(150);
   localparam logic [INTEN_W-1:0] LUMA_B = INTEN_W'(29);

   typedef enum logic [1:0] {
      KIND_DROP  = 2'd0,
      KIND_PASS  = 2'd1,
      KIND_XFORM = 2'd2
   } point_kind_type;

   typedef struct packed {
      logic                         source;
      logic signed [COORD_BITS-1:0] in_x;
      logic signed [COORD_BITS-1:0] in_y;
      logic signed [COORD_BITS-1:0] in_z;
      logic [INTEN_W-1:0]           in_intensity;
      logic [COLOR_W-1:0]           red;
      logic [COLOR_W-1:0]           green;
      logic [COLOR_W-1:0]           blue;
      logic                         finite;
      logic                         frame_end;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] out_x;
      logic signed [COORD_BITS-1:0] out_y;
      logic signed [COORD_BITS-1:0] out_z;
      logic [INTEN_W-1:0]           out_intensity;
      logic                         keep;
      logic                         out_frame_end;
   } rsp_type;

   // Per-point side data carried down the pipeline next to the arithmetic.
   typedef struct packed {
      point_kind_type               kind;
      logic signed [COORD_BITS-1:0] px;
      logic signed [COORD_BITS-1:0] py;
      logic signed [COORD_BITS-1:0] pz;
      logic [INTEN_W-1:0]           intensity;
      logic                         frame_end;
   } meta_type;

endpackage

@@ rtl/point_cloud_transform_crop.sv @@
`timescale 1ns / 1ps
// point_cloud_transform_crop: per-point merge, rigid transform and height crop.
// Depends on pctc_pkg (types, widths, register indexes).

// One point per transfer on req_, one result per point on rsp_, in order.
// Primary points (source 0) pass through with keep set; secondary points are
// dropped (x, y, z and intensity zero, keep 0) unless merge_enable is set, finite is set
// and the point is not exactly at the origin; accepted secondary points get
// p' = R*p + t, rounded half up from Q1.14, saturated to COORD_BITS, and an
// intensity of (77r + 150g + 29b) in 1/256 units. With crop_enable set, any
// point whose output z is above crop_height has keep cleared. out_frame_end
// always copies frame_end. Throughput is one point per clock while rsp_ is
// not stalled, through five register stages (capture, 16xCOORD_BITS
// multiplies, partial sums, final sum, round/saturate/crop into the output
// register), the first of which loads on the transfer edge unless stalled.
// A stall on rsp_ while rsp_valid is high freezes the whole pipeline;
// a point offered during that cycle lands in a one-entry input skid register,
// so req_stall is a flop output and rises in the cycle after that point is taken.
// Configuration is taken on any clock with csr_we high; indexes 7 and up are
// ignored. Write it only while no point is in flight.
module point_cloud_transform_crop (
   input  logic                                 clock,
   input  logic                                 reset,
   // point input
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  pctc_pkg::req_type                    req_data,
   // result output
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output pctc_pkg::rsp_type                    rsp_data,
   // configuration writes
   input  logic                                 csr_we,
   input  logic [pctc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pctc_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import pctc_pkg::*;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [ROW_W-1:0]          rot_ff [3];
   logic [TRANS_REG_W-1:0]    translation_ff;
   logic signed [CROP_W-1:0]  crop_height_ff;
   logic                      crop_enable_ff;
   logic                      merge_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff[0]       <= ROT_ROW0_RESET;
         rot_ff[1]       <= ROT_ROW1_RESET;
         rot_ff[2]       <= ROT_ROW2_RESET;
         translation_ff  <= '0;
         crop_height_ff  <= CROP_HEIGHT_RESET;
         crop_enable_ff  <= 1'b1;
         merge_enable_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROT_ROW0:     rot_ff[0]       <= csr_wdata[ROW_W-1:0];
            CSR_ROT_ROW1:     rot_ff[1]       <= csr_wdata[ROW_W-1:0];
            CSR_ROT_ROW2:     rot_ff[2]       <= csr_wdata[ROW_W-1:0];
            CSR_TRANSLATION:  translation_ff  <= csr_wdata[TRANS_REG_W-1:0];
            CSR_CROP_HEIGHT:  crop_height_ff  <= csr_wdata[CROP_W-1:0];
            CSR_CROP_ENABLE:  crop_enable_ff  <= csr_wdata[0];
            CSR_MERGE_ENABLE: merge_enable_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Flow control: one global advance, input skid register
   // ---------------------------------------------------------------------
   logic    advance;
   logic    req_xfer;
   logic    skid_valid_ff;
   req_type skid_data_ff;

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = skid_valid_ff;
   assign req_xfer  = req_valid && !skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else if (advance) begin
         skid_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!advance && req_xfer) begin
         skid_data_ff <= req_data;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: capture
   // ---------------------------------------------------------------------
   logic    s1_valid_ff;
   logic    s1_valid_in;
   req_type s1_data_ff;
   req_type s1_data_in;

   assign s1_valid_in = skid_valid_ff || req_xfer;
   assign s1_data_in  = skid_valid_ff ? skid_data_ff : req_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_data_ff <= s1_data_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: nine rotation products, classification, luminance
   // ---------------------------------------------------------------------
   logic signed [COORD_BITS-1:0] s1_p [3];
   logic                         s1_zero;
   meta_type                     s2_meta_in;
   logic signed [PROD_W-1:0]     s2_prod_in [3][3];
   logic                         s2_valid_ff;
   meta_type                     s2_meta_ff;
   logic signed [PROD_W-1:0]     s2_prod_ff [3][3];

   assign s1_p[0] = s1_data_ff.in_x;
   assign s1_p[1] = s1_data_ff.in_y;
   assign s1_p[2] = s1_data_ff.in_z;
   assign s1_zero = (s1_p[0] == '0) && (s1_p[1] == '0) && (s1_p[2] == '0);

   always_comb begin
      s2_meta_in.px        = s1_p[0];
      s2_meta_in.py        = s1_p[1];
      s2_meta_in.pz        = s1_p[2];
      s2_meta_in.frame_end = s1_data_ff.frame_end;
      if (!s1_data_ff.source) begin
         s2_meta_in.kind      = KIND_PASS;
         s2_meta_in.intensity = s1_data_ff.in_intensity;
      end else if (merge_enable_ff && s1_data_ff.finite && !s1_zero) begin
         s2_meta_in.kind      = KIND_XFORM;
         s2_meta_in.intensity = LUMA_R * INTEN_W'(s1_data_ff.red)
                              + LUMA_G * INTEN_W'(s1_data_ff.green)
                              + LUMA_B * INTEN_W'(s1_data_ff.blue);
      end else begin
         s2_meta_in.kind      = KIND_DROP;
         s2_meta_in.intensity = '0;
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            s2_prod_in[r][c] = PROD_W'($signed(rot_ff[r][ROT_W*c +: ROT_W]))
                             * PROD_W'(s1_p[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_meta_ff <= s2_meta_in;
         s2_prod_ff <= s2_prod_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: partial sums; translation goes in at Q.14 with the half bias
   // ---------------------------------------------------------------------
   localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) <<< (FRAC_BITS - 1);

   logic signed [ACC_W-1:0] s3_trans [3];
   logic signed [ACC_W-1:0] s3_part_a_in [3];
   logic signed [ACC_W-1:0] s3_part_b_in [3];
   logic                    s3_valid_ff;
   meta_type                s3_meta_ff;
   logic signed [ACC_W-1:0] s3_part_a_ff [3];
   logic signed [ACC_W-1:0] s3_part_b_ff [3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         s3_trans[r]     = ACC_W'($signed(translation_ff[TRANS_W*r +: TRANS_W]));
         s3_part_a_in[r] = ACC_W'(s2_prod_ff[r][0]) + ACC_W'(s2_prod_ff[r][1]);
         s3_part_b_in[r] = ACC_W'(s2_prod_ff[r][2]) + (s3_trans[r] <<< FRAC_BITS)
                         + ROUND_BIAS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_meta_ff   <= s2_meta_ff;
         s3_part_a_ff <= s3_part_a_in;
         s3_part_b_ff <= s3_part_b_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: full accumulation
   // ---------------------------------------------------------------------
   logic                    s4_valid_ff;
   meta_type                s4_meta_ff;
   logic signed [ACC_W-1:0] s4_acc_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_meta_ff <= s3_meta_ff;
         for (int r = 0; r < 3; r++) begin
            s4_acc_ff[r] <= s3_part_a_ff[r] + s3_part_b_ff[r];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5: floor by 2^14 (bias already added), saturate, select, crop
   // ---------------------------------------------------------------------
   function automatic logic signed [COORD_BITS-1:0] sat_coord(
      input logic signed [QUOT_W-1:0] q
   );
      logic upper_ones;
      logic upper_zeros;
      upper_ones  = &q[QUOT_W-1:COORD_BITS-1];
      upper_zeros = ~|q[QUOT_W-1:COORD_BITS-1];
      if (upper_ones || upper_zeros) begin
         sat_coord = q[COORD_BITS-1:0];
      end else if (q[QUOT_W-1]) begin
         sat_coord = {1'b1, {(COORD_BITS-1){1'b0}}};
      end else begin
         sat_coord = {1'b0, {(COORD_BITS-1){1'b1}}};
      end
   endfunction

   logic signed [COORD_BITS-1:0] s5_xf [3];
   rsp_type                      rsp_data_in;
   logic                         s5_above;
   logic                         rsp_valid_ff;
   rsp_type                      rsp_data_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         s5_xf[r] = sat_coord(s4_acc_ff[r][ACC_W-1:FRAC_BITS]);
      end
   end

   always_comb begin
      rsp_data_in.out_frame_end = s4_meta_ff.frame_end;
      rsp_data_in.out_intensity = s4_meta_ff.intensity;
      case (s4_meta_ff.kind)
         KIND_PASS: begin
            rsp_data_in.out_x = s4_meta_ff.px;
            rsp_data_in.out_y = s4_meta_ff.py;
            rsp_data_in.out_z = s4_meta_ff.pz;
         end
         KIND_XFORM: begin
            rsp_data_in.out_x = s5_xf[0];
            rsp_data_in.out_y = s5_xf[1];
            rsp_data_in.out_z = s5_xf[2];
         end
         default: begin
            rsp_data_in.out_x = '0;
            rsp_data_in.out_y = '0;
            rsp_data_in.out_z = '0;
         end
      endcase
      // point exactly at the limit stays in
      s5_above = CMP_W'(rsp_data_in.out_z) > CMP_W'(crop_height_ff);
      rsp_data_in.keep = (s4_meta_ff.kind != KIND_DROP) && !(crop_enable_ff && s5_above);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking bench for point_cloud_transform_crop, one point per transfer.
// Depends on pctc_pkg (payload types, widths, register indexes) and the block's RTL.
module tb;
   import pctc_pkg::*;

   // Saturation bounds of the body-frame coordinates.
   localparam longint COORD_MAX = (longint'(1) <<< (COORD_BITS - 1)) - 1;
   localparam longint COORD_MIN = -COORD_MAX - 1;
   localparam logic signed [COORD_BITS-1:0] P_MAX = COORD_BITS'(COORD_MAX);
   localparam logic signed [COORD_BITS-1:0] P_MIN = COORD_BITS'(COORD_MIN);

   // Index past the last register; writes there must change nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_NO_REG = 3'd7;

   // Luminance weights (1/256 units) and reset values, typed in independently.
   localparam int WEIGHT_R = 77;
   localparam int WEIGHT_G = 150;
   localparam int WEIGHT_B = 29;
   localparam logic [ROW_W-1:0] IDENT_ROW0 = 48'h0000_0000_4000;
   localparam logic [ROW_W-1:0] IDENT_ROW1 = 48'h0000_4000_0000;
   localparam logic [ROW_W-1:0] IDENT_ROW2 = 48'h4000_0000_0000;
   localparam logic signed [CROP_W-1:0] CROP_AT_RESET = 24'sd1403;

   localparam int RANDOM_POINTS = 2000;
   localparam int NUM_SETTINGS  = 7;
   // Five register stages; settle time before a register write.
   localparam int SETTLE_CYCLES = 10;
   localparam int MAX_REPORTS   = 10;
   // Run limit in ns: far above what 2000 points take under the idling used below.
   localparam int RUN_LIMIT_NS  = 2_000_000;

   // A point offered on req_: either its result is typed in, or predicted.
   typedef struct {
      bit      typed;
      rsp_type result;
   } offer_type;

   // One row of the directed stimulus.
   typedef struct {
      bit      merge;
      req_type point;
      bit      typed;
      rsp_type result;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   point_cloud_transform_crop i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bench copy of the register file, updated at the edge that writes the block.
   logic [ROW_W-1:0]       rot_row [3] = '{IDENT_ROW0, IDENT_ROW1, IDENT_ROW2};
   logic [TRANS_REG_W-1:0] xlate = '0;
   logic signed [CROP_W-1:0] crop_h = CROP_AT_RESET;
   logic                   crop_en = 1'b1;
   logic                   merge_en = 1'b0;

   offer_type    offered_points [$];  // driven on req_, transfer not yet seen
   rsp_type      due_results [$];     // accepted points, result not yet seen
   stim_row_type dir_rows [$];

   int send_idle_pct = 37;
   int recv_idle_pct = 58;
   int points_sent = 0;
   int results_seen = 0;
   int mismatch_count = 0;

   // Expected result of one point under the current registers.
   // Secondary points: p' = R*p + (t << 14), round half up, saturate.
   function automatic rsp_type transform_point(req_type p);
      longint             pos [3];
      longint             body [3];
      longint             acc;
      logic [INTEN_W-1:0] luma;
      logic               keep;
      rsp_type            r;
      int                 i;
      int                 c;
      pos[0] = longint'($signed(p.in_x));
      pos[1] = longint'($signed(p.in_y));
      pos[2] = longint'($signed(p.in_z));
      body = '{0, 0, 0};
      luma = '0;
      keep = 1'b0;
      if (p.source == 1'b0) begin
         body = pos;
         luma = p.in_intensity;
         keep = 1'b1;
      end else if (merge_en && p.finite && (pos[0] != 0 || pos[1] != 0 || pos[2] != 0)) begin
         for (i = 0; i < 3; i++) begin
            acc = longint'($signed(xlate[TRANS_W*i +: TRANS_W])) <<< FRAC_BITS;
            for (c = 0; c < 3; c++)
               acc += longint'($signed(rot_row[i][ROT_W*c +: ROT_W])) * pos[c];
            // arithmetic shift is a floor, so this is round to nearest, ties up
            acc = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            body[i] = (acc > COORD_MAX) ? COORD_MAX : (acc < COORD_MIN) ? COORD_MIN : acc;
         end
         luma = INTEN_W'(WEIGHT_R * p.red + WEIGHT_G * p.green + WEIGHT_B * p.blue);
         keep = 1'b1;
      end
      // signed compare on the output z; a point exactly at the limit stays
      if (keep && crop_en && body[2] > longint'(crop_h))
         keep = 1'b0;
      r.out_x         = COORD_BITS'(body[0]);
      r.out_y         = COORD_BITS'(body[1]);
      r.out_z         = COORD_BITS'(body[2]);
      r.out_intensity = luma;
      r.keep          = keep;
      r.out_frame_end = p.frame_end;
      return r;
   endfunction

   // Registers take the low bits of the write data; unknown indexes do nothing.
   function automatic void model_write(logic [CSR_INDEX_W-1:0] idx,
                                       logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_ROT_ROW0:     rot_row[0] = data[ROW_W-1:0];
         CSR_ROT_ROW1:     rot_row[1] = data[ROW_W-1:0];
         CSR_ROT_ROW2:     rot_row[2] = data[ROW_W-1:0];
         CSR_TRANSLATION:  xlate = data[TRANS_REG_W-1:0];
         CSR_CROP_HEIGHT:  crop_h = data[CROP_W-1:0];
         CSR_CROP_ENABLE:  crop_en = data[0];
         CSR_MERGE_ENABLE: merge_en = data[0];
         default: ;
      endcase
   endfunction

   function automatic req_type mk_point(logic src, logic signed [COORD_BITS-1:0] x,
                                        logic signed [COORD_BITS-1:0] y,
                                        logic signed [COORD_BITS-1:0] z,
                                        logic [INTEN_W-1:0] inten, logic [7:0] r,
                                        logic [7:0] g, logic [7:0] b, logic fin,
                                        logic fe);
      req_type p;
      p.source = src;
      p.in_x = x;
      p.in_y = y;
      p.in_z = z;
      p.in_intensity = inten;
      p.red = r;
      p.green = g;
      p.blue = b;
      p.finite = fin;
      p.frame_end = fe;
      return p;
   endfunction

   function automatic rsp_type mk_result(logic signed [COORD_BITS-1:0] x,
                                         logic signed [COORD_BITS-1:0] y,
                                         logic signed [COORD_BITS-1:0] z,
                                         logic [INTEN_W-1:0] inten, logic keep, logic fe);
      rsp_type r;
      r.out_x = x;
      r.out_y = y;
      r.out_z = z;
      r.out_intensity = inten;
      r.keep = keep;
      r.out_frame_end = fe;
      return r;
   endfunction

   task automatic add_row(bit merge, req_type p, bit typed, rsp_type r);
      stim_row_type row;
      row.merge = merge;
      row.point = p;
      row.typed = typed;
      row.result = r;
      dir_rows = {dir_rows, row};
   endtask

   // Mix of extremes, small values (rounding ties, near the origin), values just
   // around the crop height, and full-range noise.
   function automatic logic signed [COORD_BITS-1:0] rand_coord();
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(9))
         0:       return P_MAX;
         1:       return P_MIN;
         2, 3, 4: return COORD_BITS'($signed(w[12:0]));
         5:       return COORD_BITS'(longint'(crop_h) + $signed(w[3:0]));
         default: return w[COORD_BITS-1:0];
      endcase
   endfunction

   // Mostly well-formed points; some not finite, a few exactly at the origin.
   function automatic req_type rand_point();
      req_type     p;
      logic [31:0] w;
      w = $urandom;
      p.source       = w[0];
      p.in_x         = rand_coord();
      p.in_y         = rand_coord();
      p.in_z         = rand_coord();
      p.in_intensity = w[31:16];
      p.red          = 8'($urandom_range(255));
      p.green        = 8'($urandom_range(255));
      p.blue         = 8'($urandom_range(255));
      p.finite       = ($urandom_range(9) != 0);
      p.frame_end    = ($urandom_range(15) == 0);
      if (p.source && $urandom_range(24) == 0) begin
         p.in_x = '0;
         p.in_y = '0;
         p.in_z = '0;
      end
      return p;
   endfunction

   // One register write per call; the caller drops csr_we after the last one.
   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      model_write(idx, data);
   endtask

   // Offer one point, wait for its transfer, then maybe idle for a while.
   task automatic send_point(req_type p, bit typed, rsp_type result);
      offer_type offer;
      offer.typed = typed;
      offer.result = result;
      offered_points = {offered_points, offer};
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (!(req_valid && req_stall === 1'b0));
      points_sent++;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Stop offering and wait until every accepted point has its result.
   task automatic hold_off();
      req_valid <= 1'b0;
      while (offered_points.size() != 0 || due_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register setting k of the random part. Rotation, crop height and enable data
   // carry random upper bits so the width masking of those registers is exercised.
   task automatic load_setting(int k);
      logic [CSR_DATA_W-1:0] row0, row1, row2, offs, height, crop_on, merge_on;
      row0     = CSR_DATA_W'({$urandom, $urandom});
      row1     = CSR_DATA_W'({$urandom, $urandom});
      row2     = CSR_DATA_W'({$urandom, $urandom});
      offs     = CSR_DATA_W'({$urandom, $urandom});
      height   = CSR_DATA_W'({$urandom, $urandom});
      crop_on  = CSR_DATA_W'({$urandom, $urandom});
      merge_on = CSR_DATA_W'({$urandom, $urandom});
      crop_on[0]  = 1'b1;
      merge_on[0] = 1'b1;
      case (k)
         0: begin
            // half-unit diagonal: every odd coordinate hits a rounding tie
            row0 = CSR_DATA_W'({16'h0000, 16'h0000, 16'h2000});
            row1 = CSR_DATA_W'({16'h0000, 16'hE000, 16'h0000});
            row2 = CSR_DATA_W'({16'h2000, 16'h0000, 16'h0000});
            offs = '0;
         end
         2: begin
            // largest gain and offset: positive saturation
            row0   = CSR_DATA_W'({3{16'h7FFF}});
            row1   = row0;
            row2   = row0;
            offs   = {3{21'h0FFFFF}};
            height = CSR_DATA_W'(24'h7FFFFF);
         end
         3: begin
            // most negative gain and offset, lowest crop height
            row0   = CSR_DATA_W'({3{16'h8000}});
            row1   = row0;
            row2   = row0;
            offs   = {3{21'h100000}};
            height = CSR_DATA_W'(24'h800000);
         end
         4: crop_on[0] = 1'b0;
         5: begin
            // identity with merging off: secondary points all dropped
            row0   = CSR_DATA_W'(IDENT_ROW0);
            row1   = CSR_DATA_W'(IDENT_ROW1);
            row2   = CSR_DATA_W'(IDENT_ROW2);
            height = CSR_DATA_W'(24'($signed(10'($urandom))));
            merge_on[0] = 1'b0;
         end
         6: begin
            // quarter turn about z, the usual mounting case
            row0   = CSR_DATA_W'({16'h0000, 16'hC000, 16'h0000});
            row1   = CSR_DATA_W'({16'h0000, 16'h0000, 16'h4000});
            row2   = CSR_DATA_W'({16'h4000, 16'h0000, 16'h0000});
            height = CSR_DATA_W'(24'($signed(14'($urandom))));
         end
         default: ;
      endcase
      csr_write(CSR_ROT_ROW0, row0);
      csr_write(CSR_ROT_ROW1, row1);
      csr_write(CSR_ROT_ROW2, row2);
      csr_write(CSR_TRANSLATION, offs);
      csr_write(CSR_CROP_HEIGHT, height);
      csr_write(CSR_CROP_ENABLE, crop_on);
      csr_write(CSR_MERGE_ENABLE, merge_on);
      csr_write(CSR_NO_REG, CSR_DATA_W'({$urandom, $urandom}));
   endtask

   // Receiver: random stall, redrawn every clock.
   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);

   // Monitor: check a result transfer first, then log a point transfer, so a
   // point and a result on the same edge never race on the queues.
   always @(posedge clock) begin
      offer_type offer;
      rsp_type   want;
      if (!reset) begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            results_seen++;
            if (due_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: result with no point outstanding: x=%0d y=%0d z=%0d",
                           $time, $signed(rsp_data.out_x), $signed(rsp_data.out_y),
                           $signed(rsp_data.out_z));
            end else begin
               want = due_results.pop_front();
               if (rsp_data.out_x !== want.out_x || rsp_data.out_y !== want.out_y ||
                   rsp_data.out_z !== want.out_z ||
                   rsp_data.out_intensity !== want.out_intensity ||
                   rsp_data.keep !== want.keep ||
                   rsp_data.out_frame_end !== want.out_frame_end) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS) begin
                     $display("%0t: expected x=%0d y=%0d z=%0d int=%0d keep=%b end=%b",
                              $time, $signed(want.out_x), $signed(want.out_y),
                              $signed(want.out_z), want.out_intensity, want.keep,
                              want.out_frame_end);
                     $display("%0t: actual   x=%0d y=%0d z=%0d int=%0d keep=%b end=%b",
                              $time, $signed(rsp_data.out_x), $signed(rsp_data.out_y),
                              $signed(rsp_data.out_z), rsp_data.out_intensity,
                              rsp_data.keep, rsp_data.out_frame_end);
                  end
               end
            end
         end
         if (req_valid && req_stall === 1'b0) begin
            offer = offered_points.pop_front();
            want  = offer.typed ? offer.result : transform_point(req_data);
            due_results = {due_results, want};
         end
      end
   end

   initial begin
      int s;
      int n;
      // Directed rows. Under reset registers (merge off, identity, crop at
      // 1403): primary extremes, crop boundary, dropped secondary point.
      add_row(0, mk_point(0, P_MAX, P_MIN, P_MIN, 16'hFFFF, 0, 0, 0, 0, 1),
              1, mk_result(P_MAX, P_MIN, P_MIN, 16'hFFFF, 1, 1));
      add_row(0, mk_point(0, P_MIN, P_MAX, P_MAX, 16'h0000, 8'hFF, 8'hFF, 8'hFF, 1, 0),
              1, mk_result(P_MIN, P_MAX, P_MAX, 16'h0000, 0, 0));
      add_row(0, mk_point(0, 5, -7, 1403, 16'h1234, 0, 0, 0, 1, 0),
              1, mk_result(5, -7, 1403, 16'h1234, 1, 0));
      add_row(0, mk_point(0, 5, -7, 1404, 16'h1234, 0, 0, 0, 1, 1),
              1, mk_result(5, -7, 1404, 16'h1234, 0, 1));
      add_row(0, mk_point(1, 100, 200, 300, 16'hAAAA, 8'hFF, 8'hFF, 8'hFF, 1, 1),
              1, mk_result(0, 0, 0, 0, 0, 1));
      // Merge on: origin and non-finite drops, identity transform, luminance.
      add_row(1, mk_point(1, 0, 0, 0, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1, 0),
              1, mk_result(0, 0, 0, 0, 0, 0));
      add_row(1, mk_point(1, 10, 20, 30, 16'h0000, 1, 2, 3, 0, 1),
              1, mk_result(0, 0, 0, 0, 0, 1));
      add_row(1, mk_point(1, 1, 2, 3, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1, 0),
              1, mk_result(1, 2, 3, 16'd65280, 1, 0));
      add_row(1, mk_point(1, -1, 0, 1404, 16'h0000, 0, 0, 0, 1, 1),
              1, mk_result(-1, 0, 1404, 0, 0, 1));
      add_row(1, mk_point(1, P_MAX, P_MIN, P_MIN, 16'h0000, 0, 0, 0, 1, 0), 0, '0);
      add_row(1, mk_point(1, P_MIN, P_MAX, P_MAX, 16'h5555, 8'hFF, 8'hFF, 8'hFF, 1, 1),
              0, '0);
      add_row(1, mk_point(1, -1, 0, 0, 16'h0000, 8'hFF, 0, 0, 1, 0), 0, '0);
      add_row(1, mk_point(1, 0, 1, 0, 16'h0000, 0, 8'hFF, 0, 1, 0), 0, '0);
      add_row(1, mk_point(1, 0, 0, -1, 16'h0000, 0, 0, 8'hFF, 1, 0), 0, '0);
      add_row(1, mk_point(1, 7, 7, 1403, 16'hFFFF, 8'h80, 8'h01, 8'h7F, 1, 1), 0, '0);
      add_row(1, mk_point(0, 9, -9, 0, 16'h8001, 8'hFF, 8'hFF, 8'hFF, 0, 0), 0, '0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part; merge_enable is toggled only with nothing in flight.
      foreach (dir_rows[n]) begin
         if (dir_rows[n].merge != merge_en) begin
            hold_off();
            csr_write(CSR_MERGE_ENABLE, CSR_DATA_W'(dir_rows[n].merge));
            csr_we <= 1'b0;
         end
         send_point(dir_rows[n].point, dir_rows[n].typed, dir_rows[n].result);
      end

      // Random part: several register settings, idling pattern per setting.
      for (s = 0; s < NUM_SETTINGS; s++) begin
         hold_off();
         load_setting(s);
         csr_we <= 1'b0;
         if (s < 3) begin
            send_idle_pct = 37;
            recv_idle_pct = 58;
         end else if (s < 5) begin
            send_idle_pct = 58;
            recv_idle_pct = 37;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (n = 0; n < RANDOM_POINTS / NUM_SETTINGS; n++) begin
            // one full drain in the middle of a stream
            if (s == 3 && n == 100)
               hold_off();
            send_point(rand_point(), 1'b0, '0);
         end
      end
      hold_off();

      $display("ran %0d points (%0d directed) over %0d register settings",
               points_sent, dir_rows.size(), NUM_SETTINGS + 1);
      $display("checked %0d results, %0d mismatching", results_seen, mismatch_count);
      if (mismatch_count == 0 && due_results.size() == 0)
         $display("point_cloud_transform_crop: match");
      else
         $display("point_cloud_transform_crop: mismatch");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #RUN_LIMIT_NS;
      $display("point_cloud_transform_crop: mismatch");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/pctc_pkg.sv
rtl/point_cloud_transform_crop.sv
tb/tb.sv
